@@ hdl/ffb_pkg.sv @@
// ----------------------------------------------------------------------------
// Framebuffer fill and blend package
// Shared types and constants for the drawing engine and its blend unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ffb_pkg;

   // Width of one color channel and of the blend weight.
   localparam int CHAN_W = 8;
   localparam int PIXEL_W = 3 * CHAN_W;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int DIM_W = 9;
   localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

   // Register indexes (byte address bit 2).
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // Command codes.
   typedef enum logic [2:0] {
      CMD_CLEAR = 3'd0,
      CMD_SET   = 3'd1,
      CMD_BLEND = 3'd2,
      CMD_BOX   = 3'd3,
      CMD_HRUN  = 3'd4,
      CMD_VRUN  = 3'd5,
      CMD_READ  = 3'd6
   } cmd_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLIP,
      ST_BOUND,
      ST_BASE,
      ST_WALK,
      ST_READ,
      ST_MUL,
      ST_DIV,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

@@ hdl/framebuffer_fill_and_blend_top.sv @@
// ----------------------------------------------------------------------------
// Framebuffer fill and blend engine
// A 2D drawing engine over an internal 24-bit RGB frame store.
// ----------------------------------------------------------------------------
// The walk writes the pixels left after clipping at one store write a cycle; a new
// command is accepted only once the last one has finished. A result not yet taken when
// the next command ends holds that command until rsp_ready. Reset returns the sequencer
// to idle, drops rsp_valid and sets both dimensions to 256; the store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module framebuffer_fill_and_blend_top #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,

   // Command channel.
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [2:0]  req_type,
   input  wire logic [15:0] req_x_pos,
   input  wire logic [15:0] req_y_pos,
   input  wire logic [15:0] req_run_width,
   input  wire logic [15:0] req_run_height,
   input  wire logic [23:0] req_color,
   input  wire logic [7:0]  req_alpha,

   // Result channel.
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [23:0] rsp_read_color,

   // Configuration port.
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [ffb_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [ffb_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output      logic [ffb_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output      logic                            csr_pready
);

   // Geometry derived from the maximum image size.
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int PW = YW + WW;

   // ------------------------------------------------------------------------
   // Configuration registers. The active size saturates at the maximum.
   // ------------------------------------------------------------------------
   logic [ffb_pkg::DIM_W-1:0] width_ff;
   logic [ffb_pkg::DIM_W-1:0] height_ff;
   logic csr_write;
   logic [WW-1:0] eff_w;
   logic [HW-1:0] eff_h;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ffb_pkg::DIM_RESET;
         height_ff <= ffb_pkg::DIM_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            ffb_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[ffb_pkg::DIM_W-1:0];
            ffb_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[ffb_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         ffb_pkg::REG_IMAGE_WIDTH:  csr_prdata = 32'(width_ff);
         ffb_pkg::REG_IMAGE_HEIGHT: csr_prdata = 32'(height_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_comb begin
      eff_w = (32'(width_ff) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(width_ff);
      eff_h = (32'(height_ff) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(height_ff);
   end

   // ------------------------------------------------------------------------
   // Command capture. The word is held for the whole command.
   // ------------------------------------------------------------------------
   ffb_pkg::state_type state_ff;
   ffb_pkg::state_type state_in;

   ffb_pkg::cmd_type   type_ff;
   logic signed [15:0] x_ff;
   logic signed [15:0] y_ff;
   logic signed [15:0] rw_ff;
   logic signed [15:0] rh_ff;
   logic [23:0]        color_ff;
   logic [7:0]         alpha_ff;

   // Requested span (before clipping) and clipped span, both inclusive.
   logic signed [17:0] sx0_ff, sx1_ff, sy0_ff, sy1_ff;
   logic signed [17:0] sx0_in, sx1_in, sy0_in, sy1_in;
   logic               size_ok_ff, size_ok_in;
   logic signed [17:0] cx0_ff, cx1_ff, cy0_ff, cy1_ff;
   logic signed [17:0] wm1, hm1;
   logic               empty_ff, empty_in;

   // Walk counters and the shared address adder.
   logic [XW-1:0] ix_ff;
   logic [YW-1:0] iy_ff;
   logic [AW-1:0] addr_ff;
   logic [AW-1:0] row_step_ff;
   logic [PW-1:0] row_base;
   logic          row_last, col_last;

   // Blend channel sequencing.
   logic [1:0]  ch_ff;
   logic [23:0] pix_ff;
   logic [7:0]  blend_src, blend_dst, blend_res;

   // Frame store.
   logic [23:0] frame_mem [DEPTH];
   logic [23:0] rd_ff;

   // Result register.
   logic        rsp_valid_ff;
   logic [23:0] rsp_color_ff;
   logic [23:0] rsp_color_in;

   // Sequencer outputs.
   logic accept;
   logic mem_we, mem_re, blend_load, blend_take, rsp_load;
   logic [23:0] mem_wdata;

   assign accept = req_valid & req_ready;
   assign col_last = (ix_ff == cx1_ff[XW-1:0]);
   assign row_last = (iy_ff == cy1_ff[YW-1:0]);

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff  <= ffb_pkg::cmd_type'(req_type);
         x_ff     <= $signed(req_x_pos);
         y_ff     <= $signed(req_y_pos);
         rw_ff    <= $signed(req_run_width);
         rh_ff    <= $signed(req_run_height);
         color_ff <= req_color;
         alpha_ff <= req_alpha;
      end
   end

   // ------------------------------------------------------------------------
   // Clipping. The first step forms the span each command asks for; the
   // second clamps it to the active image. An empty span writes nothing.
   // ------------------------------------------------------------------------
   always_comb begin
      wm1 = $signed(18'(eff_w)) - 18'sd1;
      hm1 = $signed(18'(eff_h)) - 18'sd1;
      sx0_in = 18'(x_ff);
      sy0_in = 18'(y_ff);
      sx1_in = 18'(x_ff);
      sy1_in = 18'(y_ff);
      size_ok_in = 1'b1;
      unique case (type_ff)
         ffb_pkg::CMD_CLEAR: begin
            sx0_in = '0;
            sy0_in = '0;
            sx1_in = wm1;
            sy1_in = hm1;
         end
         ffb_pkg::CMD_SET, ffb_pkg::CMD_BLEND, ffb_pkg::CMD_READ: ;
         ffb_pkg::CMD_BOX: begin
            sx1_in = 18'(x_ff) + 18'(rw_ff) - 18'sd1;
            sy1_in = 18'(y_ff) + 18'(rh_ff) - 18'sd1;
            size_ok_in = (rw_ff > 16'sd0) && (rh_ff > 16'sd0);
         end
         ffb_pkg::CMD_HRUN: begin
            sx1_in = 18'(x_ff) + 18'(rw_ff) - 18'sd1;
            size_ok_in = (rw_ff > 16'sd0);
         end
         ffb_pkg::CMD_VRUN: begin
            sy1_in = 18'(y_ff) + 18'(rh_ff) - 18'sd1;
            size_ok_in = (rh_ff > 16'sd0);
         end
         default: size_ok_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ffb_pkg::ST_CLIP) begin
         sx0_ff     <= sx0_in;
         sx1_ff     <= sx1_in;
         sy0_ff     <= sy0_in;
         sy1_ff     <= sy1_in;
         size_ok_ff <= size_ok_in;
      end
      if (state_ff == ffb_pkg::ST_BOUND) begin
         cx0_ff <= (sx0_ff < 18'sd0) ? 18'sd0 : sx0_ff;
         cy0_ff <= (sy0_ff < 18'sd0) ? 18'sd0 : sy0_ff;
         cx1_ff <= (sx1_ff > wm1) ? wm1 : sx1_ff;
         cy1_ff <= (sy1_ff > hm1) ? hm1 : sy1_ff;
      end
   end

   assign empty_in = !size_ok_ff || (cx0_ff > cx1_ff) || (cy0_ff > cy1_ff);

   // ------------------------------------------------------------------------
   // Address walk. The first address is y0 * width + x0; along a row the
   // address steps by one, and at the end of a row the shared adder adds
   // width minus (x1 - x0) to land on the next row's first pixel.
   // ------------------------------------------------------------------------
   assign row_base = PW'(cy0_ff[YW-1:0]) * PW'(eff_w);

   always_ff @(posedge clock) begin
      if (state_ff == ffb_pkg::ST_BASE) begin
         empty_ff    <= empty_in;
         ix_ff       <= cx0_ff[XW-1:0];
         iy_ff       <= cy0_ff[YW-1:0];
         addr_ff     <= AW'(row_base) + AW'(cx0_ff[XW-1:0]);
         row_step_ff <= AW'(eff_w) - AW'(cx1_ff[XW-1:0]) + AW'(cx0_ff[XW-1:0]);
      end else if (state_ff == ffb_pkg::ST_WALK) begin
         if (col_last) begin
            ix_ff   <= cx0_ff[XW-1:0];
            iy_ff   <= iy_ff + YW'(1);
            addr_ff <= addr_ff + row_step_ff;
         end else begin
            ix_ff   <= ix_ff + XW'(1);
            addr_ff <= addr_ff + AW'(1);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Frame store: one port, registered read data.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[addr_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= frame_mem[addr_ff];
      end
   end

   // ------------------------------------------------------------------------
   // Blend. One channel unit serves red, green and blue in turn; the old
   // pixel stays in the read register while the new one is assembled.
   // ------------------------------------------------------------------------
   always_comb begin
      case (ch_ff)
         2'd0: begin
            blend_src = color_ff[23:16];
            blend_dst = rd_ff[23:16];
         end
         2'd1: begin
            blend_src = color_ff[15:8];
            blend_dst = rd_ff[15:8];
         end
         default: begin
            blend_src = color_ff[7:0];
            blend_dst = rd_ff[7:0];
         end
      endcase
   end

   ffb_blend_unit u_blend (
      .clock  (clock),
      .load   (blend_load),
      .src    (blend_src),
      .dst    (blend_dst),
      .alpha  (alpha_ff),
      .result (blend_res)
   );

   always_ff @(posedge clock) begin
      if (state_ff == ffb_pkg::ST_READ) begin
         ch_ff <= 2'd0;
      end else if (blend_take) begin
         ch_ff <= ch_ff + 2'd1;
         case (ch_ff)
            2'd0:    pix_ff[23:16] <= blend_res;
            2'd1:    pix_ff[15:8]  <= blend_res;
            default: pix_ff[7:0]   <= blend_res;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffb_pkg::ST_IDLE: begin
            if (req_valid) state_in = ffb_pkg::ST_CLIP;
         end
         ffb_pkg::ST_CLIP:  state_in = ffb_pkg::ST_BOUND;
         ffb_pkg::ST_BOUND: state_in = ffb_pkg::ST_BASE;
         ffb_pkg::ST_BASE: begin
            if (empty_in) begin
               state_in = ffb_pkg::ST_DONE;
            end else if (type_ff == ffb_pkg::CMD_BLEND || type_ff == ffb_pkg::CMD_READ) begin
               state_in = ffb_pkg::ST_READ;
            end else begin
               state_in = ffb_pkg::ST_WALK;
            end
         end
         ffb_pkg::ST_WALK: begin
            if (col_last && row_last) state_in = ffb_pkg::ST_DONE;
         end
         ffb_pkg::ST_READ: begin
            state_in = (type_ff == ffb_pkg::CMD_BLEND) ? ffb_pkg::ST_MUL : ffb_pkg::ST_DONE;
         end
         ffb_pkg::ST_MUL: state_in = ffb_pkg::ST_DIV;
         ffb_pkg::ST_DIV: begin
            state_in = (ch_ff == 2'd2) ? ffb_pkg::ST_WRITE : ffb_pkg::ST_MUL;
         end
         ffb_pkg::ST_WRITE: state_in = ffb_pkg::ST_DONE;
         ffb_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ffb_pkg::ST_IDLE;
         end
         default: state_in = ffb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_wdata  = color_ff;
      blend_load = 1'b0;
      blend_take = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ffb_pkg::ST_IDLE:  req_ready = 1'b1;
         ffb_pkg::ST_WALK:  mem_we = 1'b1;
         ffb_pkg::ST_READ:  mem_re = 1'b1;
         ffb_pkg::ST_MUL:   blend_load = 1'b1;
         ffb_pkg::ST_DIV:   blend_take = 1'b1;
         ffb_pkg::ST_WRITE: begin
            mem_we    = 1'b1;
            mem_wdata = pix_ff;
         end
         ffb_pkg::ST_DONE:  rsp_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // ------------------------------------------------------------------------
   // Result register. Every command returns one word; only a read that hits
   // the active image carries a pixel, all others carry zero.
   // ------------------------------------------------------------------------
   assign rsp_color_in = (type_ff == ffb_pkg::CMD_READ && !empty_ff) ? rd_ff : 24'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_color_ff <= rsp_color_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_color = rsp_color_ff;

endmodule

`default_nettype wire

@@ hdl/ffb_blend_unit.sv @@
// ----------------------------------------------------------------------------
// Framebuffer blend channel unit
// Blends one color channel: a registered signed product,
// then a divide by 255 truncated toward zero and the add of the old value.
// ----------------------------------------------------------------------------
`default_nettype none

module ffb_blend_unit (
   input  wire logic                      clock,
   input  wire logic                      load,
   input  wire logic [ffb_pkg::CHAN_W-1:0] src,
   input  wire logic [ffb_pkg::CHAN_W-1:0] dst,
   input  wire logic [ffb_pkg::CHAN_W-1:0] alpha,
   output      logic [ffb_pkg::CHAN_W-1:0] result
);

   logic signed [17:0] prod_ff;
   logic signed [17:0] prod_in;
   logic [ffb_pkg::CHAN_W-1:0] dst_ff;
   logic signed [8:0] diff;
   logic neg;
   logic [15:0] mag;
   logic [16:0] scaled;
   logic [ffb_pkg::CHAN_W-1:0] quot;

   always_comb begin
      diff = $signed({1'b0, src}) - $signed({1'b0, dst});
      prod_in = 18'(diff) * $signed({10'b0, alpha});
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
         dst_ff  <= dst;
      end
   end

   // The magnitude is at most 255*255, where (m + m/256 + 1)/256 equals m/255.
   always_comb begin
      neg    = prod_ff[17];
      mag    = neg ? 16'(-prod_ff) : 16'(prod_ff);
      scaled = 17'(mag) + 17'(mag[15:8]) + 17'd1;
      quot   = scaled[15:8];
      result = neg ? dst_ff - quot : dst_ff + quot;
   end

endmodule

`default_nettype wire
